/* src/guid_keyed_offer_cache_core_defines.svh */
// Assertion macros shared by the offer cache RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef GUID_KEYED_OFFER_CACHE_CORE_DEFINES_SVH
`define GUID_KEYED_OFFER_CACHE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is high
`define GKOC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("offer cache check failed");
// Clocked check that also holds through reset
`define GKOC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("offer cache check failed");
`else
`define GKOC_ASSERT(lbl, clk, rst, prop)
`define GKOC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* src/gkoc_pkg.sv */
// Shared types and constants for the GUID keyed offer cache.
// No dependencies; used by the cell and the top level.
package gkoc_pkg;

   localparam int DEFAULT_ENTRIES = 32;

   // Command codes
   localparam logic [1:0] CMD_STORE  = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // Stored offer fields
   typedef struct packed {
      logic [31:0] relid;
      logic [31:0] conn_handle;
      logic [7:0]  mon_index;
      logic        mon_granted;
      logic        dedicated_interrupt;
   } payload_type;

   // 128-bit GUID key
   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } key_type;

   // Scan token that walks the cell chain
   typedef struct packed {
      logic        active;
      logic        hit;
      logic        free_found;
      payload_type data;
   } tok_type;

   // Broadcast update from the controller to all cells
   typedef struct packed {
      logic        we;
      logic        clr;
      key_type     key;
      payload_type data;
   } wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

/* src/gkoc_if.sv */
// Valid/ready channel interfaces for the offer cache request and response.
// No dependencies.
interface gkoc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [63:0] guid_high;
   logic [63:0] guid_low;
   logic [31:0] relid;
   logic [31:0] conn_handle;
   logic [7:0]  mon_index;
   logic        mon_granted;
   logic        dedicated_interrupt;

   modport source (
      output valid, command, guid_high, guid_low, relid, conn_handle,
             mon_index, mon_granted, dedicated_interrupt,
      input  ready
   );
   modport sink (
      input  valid, command, guid_high, guid_low, relid, conn_handle,
             mon_index, mon_granted, dedicated_interrupt,
      output ready
   );
endinterface

interface gkoc_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] out_relid;
   logic [31:0] out_conn_handle;
   logic [7:0]  out_mon_index;
   logic        out_mon_granted;
   logic        out_dedicated_interrupt;

   modport source (
      output valid, found, out_relid, out_conn_handle, out_mon_index,
             out_mon_granted, out_dedicated_interrupt,
      input  ready
   );
   modport sink (
      input  valid, found, out_relid, out_conn_handle, out_mon_index,
             out_mon_granted, out_dedicated_interrupt,
      output ready
   );
endinterface

/* src/guid_keyed_offer_cache_core.sv */
// Top level of the GUID keyed offer cache: controller and row of entry cells.
// Depends on gkoc_pkg, gkoc_if.sv, gkoc_cell and the assertion macro header.
`include "guid_keyed_offer_cache_core_defines.svh"

// Fully associative offer table of ENTRIES slots keyed by a 128-bit GUID.
// Every command (store, lookup, clear) starts the same way: a scan token
// walks the row of cells, one cell per cycle, collecting the first matching
// entry and the first free slot; the controller then writes the chosen slot
// on a store (or clears all valid bits on a clear) and registers the single
// response. One command is in flight at a time, and the time from the request
// transfer to the response is set by the length of the cell chain. The next
// request is taken in the cycle the response appears. While a response still
// waits for its transfer, the following command holds in its commit step
// until the response register frees up.
module guid_keyed_offer_cache_core #(
   parameter int ENTRIES = gkoc_pkg::DEFAULT_ENTRIES
) (
   input  logic       clock,
   input  logic       reset,
   gkoc_req_if.sink   req_chan,
   gkoc_rsp_if.source rsp_chan
);
   import gkoc_pkg::*;

   localparam int IW = $clog2(ENTRIES);

   state_type     state_ff;
   state_type     state_in;
   logic [1:0]    cmd_ff;
   key_type       key_ff;
   payload_type   data_ff;
   logic          start_ff;
   tok_type       fin_tok_ff;
   logic [IW-1:0] fin_hit_idx_ff;
   logic [IW-1:0] fin_free_idx_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          rsp_found_ff;
   payload_type   rsp_data_ff;

   logic          accept;
   logic          rsp_free;
   logic          commit;
   logic          lookup_hit;
   wr_type        wr;
   logic [IW-1:0] wr_idx;

   tok_type       tok_chain      [0:ENTRIES];
   logic [IW-1:0] hit_idx_chain  [0:ENTRIES];
   logic [IW-1:0] free_idx_chain [0:ENTRIES];
   logic [ENTRIES-1:0] valid_vec;
   logic [ENTRIES:0]   active_vec;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // Token injected at the head of the chain
   always_comb begin
      tok_chain[0]        = '0;
      tok_chain[0].active = start_ff;
   end
   assign hit_idx_chain[0]  = '0;
   assign free_idx_chain[0] = '0;
   assign active_vec[0]     = start_ff;

   // Row of entry cells
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      gkoc_cell #(
         .IW    (IW),
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .probe_key    (key_ff),
         .tok_in       (tok_chain[i]),
         .hit_idx_in   (hit_idx_chain[i]),
         .free_idx_in  (free_idx_chain[i]),
         .wr           (wr),
         .wr_idx       (wr_idx),
         .tok_out      (tok_chain[i+1]),
         .hit_idx_out  (hit_idx_chain[i+1]),
         .free_idx_out (free_idx_chain[i+1]),
         .valid_out    (valid_vec[i])
      );
      assign active_vec[i+1] = tok_chain[i+1].active;
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and controller outputs
   always_comb begin
      state_in       = state_ff;
      req_chan.ready = 1'b0;
      commit         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok_chain[ENTRIES].active) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Request capture and scan start
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
      end else begin
         start_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff                       <= req_chan.command;
         key_ff.high                  <= req_chan.guid_high;
         key_ff.low                   <= req_chan.guid_low;
         data_ff.relid                <= req_chan.relid;
         data_ff.conn_handle          <= req_chan.conn_handle;
         data_ff.mon_index            <= req_chan.mon_index;
         data_ff.mon_granted          <= req_chan.mon_granted;
         data_ff.dedicated_interrupt  <= req_chan.dedicated_interrupt;
      end
   end

   // Scan result at the tail of the chain
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN && tok_chain[ENTRIES].active) begin
         fin_tok_ff      <= tok_chain[ENTRIES];
         fin_hit_idx_ff  <= hit_idx_chain[ENTRIES];
         fin_free_idx_ff <= free_idx_chain[ENTRIES];
      end
   end

   // Table update: matching entry, else first free slot, else slot 0
   always_comb begin
      wr.we   = commit && (cmd_ff == CMD_STORE);
      wr.clr  = commit && (cmd_ff == CMD_CLEAR);
      wr.key  = key_ff;
      wr.data = data_ff;
      if (fin_tok_ff.hit) begin
         wr_idx = fin_hit_idx_ff;
      end else if (fin_tok_ff.free_found) begin
         wr_idx = fin_free_idx_ff;
      end else begin
         wr_idx = '0;
      end
   end

   // Response register
   assign lookup_hit = (cmd_ff == CMD_LOOKUP) && fin_tok_ff.hit;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_found_ff <= lookup_hit;
         rsp_data_ff  <= lookup_hit ? fin_tok_ff.data : '0;
      end
   end

   assign rsp_chan.valid                   = rsp_valid_ff;
   assign rsp_chan.found                   = rsp_found_ff;
   assign rsp_chan.out_relid               = rsp_data_ff.relid;
   assign rsp_chan.out_conn_handle         = rsp_data_ff.conn_handle;
   assign rsp_chan.out_mon_index           = rsp_data_ff.mon_index;
   assign rsp_chan.out_mon_granted         = rsp_data_ff.mon_granted;
   assign rsp_chan.out_dedicated_interrupt = rsp_data_ff.dedicated_interrupt;

   // Checks
   `GKOC_ASSERT(a_single_token, clock, reset, $onehot0(active_vec))
   `GKOC_ASSERT(a_idle_no_token, clock, reset, (state_ff == ST_IDLE) |-> !(|active_vec))
   `GKOC_ASSERT(a_clear_empties, clock, reset, wr.clr |=> (valid_vec == '0))
   `GKOC_ASSERT(a_store_fills, clock, reset, wr.we |=> (valid_vec != '0))

endmodule

/* src/gkoc_cell.sv */
// One table entry of the offer cache plus its stage of the scan chain.
// Depends on gkoc_pkg.
module gkoc_cell #(
   parameter int IW    = 5,
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  gkoc_pkg::key_type probe_key,
   input  gkoc_pkg::tok_type tok_in,
   input  logic [IW-1:0]     hit_idx_in,
   input  logic [IW-1:0]     free_idx_in,
   input  gkoc_pkg::wr_type  wr,
   input  logic [IW-1:0]     wr_idx,
   output gkoc_pkg::tok_type tok_out,
   output logic [IW-1:0]     hit_idx_out,
   output logic [IW-1:0]     free_idx_out,
   output logic              valid_out
);
   import gkoc_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic          valid_ff;
   key_type       key_ff;
   payload_type   data_ff;
   tok_type       tok_ff;
   tok_type       tok_in_nxt;
   logic [IW-1:0] hit_idx_ff;
   logic [IW-1:0] hit_idx_in_nxt;
   logic [IW-1:0] free_idx_ff;
   logic [IW-1:0] free_idx_in_nxt;
   logic          match;
   logic          sel;

   assign match = valid_ff && (key_ff == probe_key);
   assign sel   = wr.we && (wr_idx == MY_IDX);

   // Token update: first match and first free slot win, lowest index first
   always_comb begin
      tok_in_nxt      = tok_in;
      hit_idx_in_nxt  = hit_idx_in;
      free_idx_in_nxt = free_idx_in;
      if (tok_in.active) begin
         if (!tok_in.hit && match) begin
            tok_in_nxt.hit  = 1'b1;
            tok_in_nxt.data = data_ff;
            hit_idx_in_nxt  = MY_IDX;
         end
         if (!tok_in.free_found && !valid_ff) begin
            tok_in_nxt.free_found = 1'b1;
            free_idx_in_nxt       = MY_IDX;
         end
      end
   end

   // Chain stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff      <= tok_in_nxt;
         hit_idx_ff  <= hit_idx_in_nxt;
         free_idx_ff <= free_idx_in_nxt;
      end
   end

   // Entry valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.clr) begin
         valid_ff <= 1'b0;
      end else if (sel) begin
         valid_ff <= 1'b1;
      end
   end

   // Entry key and offer
   always_ff @(posedge clock) begin
      if (sel) begin
         key_ff  <= wr.key;
         data_ff <= wr.data;
      end
   end

   assign tok_out      = tok_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;
   assign valid_out    = valid_ff;

endmodule
